### src/dcilm_pkg.sv
package dcilm_pkg;

  localparam int unsigned NumCores  = 2;
  localparam int unsigned CoreIdW   = 2;
  localparam int unsigned NowW      = 63;
  localparam int unsigned CntW      = 32;
  localparam int unsigned LoadW     = 15;
  localparam int unsigned WindowW   = 24;
  localparam int unsigned CalibW    = 30;
  localparam int unsigned CfgDataW  = 30;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 32;

  // shared divider: 52-bit numerator (count*1e6 or scaled max-rate), 63-bit denominator
  localparam int unsigned DivNumW   = 52;
  localparam int unsigned DivDenW   = 63;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [WindowW-1:0] WindowReset = 24'd250000;
  localparam logic [CalibW-1:0]  CalibReset  = 30'd3000000;
  localparam logic [19:0]        UsPerSec    = 20'd1000000;
  localparam logic [LoadW-1:0]   FullLoad    = 15'd25600;

  localparam logic OpIdle  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_CALIB  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_IDLE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [CoreIdW-1:0]   core_id;
    logic [NowW-1:0]      now_us;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_MUL,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_APPLY,
    ST_LOAD_MUL,
    ST_LOAD_GO,
    ST_LOAD_WAIT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

### src/dual_core_idle_load_monitor_core.sv
// Load monitor for two cores driven by idle events. An idle event (tuser 0) bumps the
// saturating idle counter of core 0 or 1; events for cores 2 and 3 are dropped
// on entry. A query (tuser 1) carries the time in microseconds and returns one beat with the
// selected core's load, the mean load (1/256 percent units) and the calibrated flag. Beats
// enter a short queue, so the input keeps flowing while the back end works on a query, until the
// queue fills. A query that only records the time, does not advance it or falls inside the
// window goes straight to the result; one that updates runs the shared restoring divider, which
// produces one quotient bit per cycle over 52 bits, once per core for the idle rate and, after
// calibration, once more for the load of each core whose load is not zero. Configuration writes
// land immediately and should only be issued while no query is in flight.
module dual_core_idle_load_monitor_core #(
  parameter int unsigned FifoDepth = dcilm_pkg::FifoDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dcilm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dcilm_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] core_id, [64:2] now_us, [71:65] zero
  input  logic [dcilm_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] op
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [14:0] load_core, [29:15] load_total, [30] is_calibrated, [31] zero
  output logic [dcilm_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                push;
  dcilm_pkg::item_t    push_item;
  logic                fifo_full;
  logic                fifo_valid;
  logic                fifo_pop;
  dcilm_pkg::item_t    head_item;
  dcilm_pkg::div_req_t div_req;
  dcilm_pkg::div_rsp_t div_rsp;

  dcilm_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  dcilm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .item_o  (head_item)
  );

  dcilm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dcilm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fifo_valid_i    (fifo_valid),
    .fifo_item_i     (head_item),
    .fifo_pop_o      (fifo_pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

### src/dcilm_front.sv
module dcilm_front (
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] core_id, [64:2] now_us, rest zero
  input  logic [dcilm_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [0] op
  input  logic                               s_axis_tuser_i,
  input  logic                               fifo_full_i,
  output logic                               push_o,
  output dcilm_pkg::item_t                   item_o
);

  logic accept;
  logic drop;

  assign s_axis_tready_o = !fifo_full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_o.kind    = (s_axis_tuser_i == dcilm_pkg::OpQuery) ? dcilm_pkg::KIND_QUERY
                                                             : dcilm_pkg::KIND_IDLE;
    item_o.core_id = s_axis_tdata_i[dcilm_pkg::CoreIdW-1:0];
    item_o.now_us  = s_axis_tdata_i[dcilm_pkg::CoreIdW +: dcilm_pkg::NowW];
  end

  // idle events for cores that do not exist never reach the back end
  assign drop   = (item_o.kind == dcilm_pkg::KIND_IDLE) &&
                  (item_o.core_id >= dcilm_pkg::CoreIdW'(dcilm_pkg::NumCores));
  assign push_o = accept && !drop;

endmodule

### src/dcilm_fifo.sv
module dcilm_fifo #(
  parameter int unsigned Depth = dcilm_pkg::FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dcilm_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dcilm_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  dcilm_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (lvl_q == LvlW'(Depth));
  assign valid_o = (lvl_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (!do_push && do_pop) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### src/dcilm_div.sv
module dcilm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcilm_pkg::div_req_t req_i,
  output dcilm_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NumW  = dcilm_pkg::DivNumW;
  localparam int unsigned DenW  = dcilm_pkg::DivDenW;
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    rem_sub;
  logic             fits;

  // restoring division, one quotient bit a cycle; quotient shifts into num_q
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepW'(NumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      num_q <= {num_q[NumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

### src/dcilm_back.sv
module dcilm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcilm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dcilm_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                fifo_valid_i,
  input  dcilm_pkg::item_t                    fifo_item_i,
  output logic                                fifo_pop_o,
  output dcilm_pkg::div_req_t                 div_req_o,
  input  dcilm_pkg::div_rsp_t                 div_rsp_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [dcilm_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned NowW  = dcilm_pkg::NowW;
  localparam int unsigned CntW  = dcilm_pkg::CntW;
  localparam int unsigned LoadW = dcilm_pkg::LoadW;
  localparam int unsigned NC    = dcilm_pkg::NumCores;

  dcilm_pkg::state_e state_q, state_d;

  logic [CntW-1:0]                   cnt_q   [NC];
  logic [CntW-1:0]                   max_q   [NC];
  logic [CntW-1:0]                   rate_q  [NC];
  logic [LoadW-1:0]                  load_q  [NC];
  logic [NowW-1:0]                   last_q;
  logic                              tvalid_q;
  logic [NowW-1:0]                   cal_start_q;
  logic                              cal_started_q;
  logic                              cal_q;
  logic [dcilm_pkg::WindowW-1:0]     win_q;
  logic [dcilm_pkg::CalibW-1:0]      calus_q;
  logic [NowW-1:0]                   now_q;
  logic [dcilm_pkg::CoreIdW-1:0]     core_q;
  logic [NowW-1:0]                   dt_q;
  logic                              ci_q;
  logic [dcilm_pkg::DivNumW-1:0]     prod_q;
  logic                              out_valid_q;
  logic [dcilm_pkg::OutDataW-1:0]    out_data_q;

  logic                              is_query;
  logic [NowW-1:0]                   dt_c;
  logic                              skip_update;
  logic [NowW-1:0]                   eff_start;
  logic                              cal_end;
  logic [CntW-1:0]                   new_max [NC];
  logic                              load_zero;
  logic [CntW-1:0]                   rate_sat;
  logic                              out_free;
  logic                              out_load;
  logic [LoadW-1:0]                  load_sel;
  logic [LoadW:0]                    load_sum;

  assign is_query = (fifo_item_i.kind == dcilm_pkg::KIND_QUERY);
  assign dt_c     = fifo_item_i.now_us - last_q;
  // backwards time, zero elapsed time and a window not yet gone all leave the state alone
  assign skip_update = (fifo_item_i.now_us <= last_q) || (dt_c < NowW'(win_q));

  assign eff_start = cal_started_q ? cal_start_q : now_q;
  assign cal_end   = (now_q >= eff_start) && ((now_q - eff_start) > NowW'(calus_q));

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      new_max[i] = (rate_q[i] > max_q[i]) ? rate_q[i] : max_q[i];
      if (cal_end && (new_max[i] == '0)) begin
        new_max[i] = CntW'(1);
      end
    end
  end

  assign load_zero = (max_q[ci_q] == '0) || (rate_q[ci_q] >= max_q[ci_q]);
  assign rate_sat  = (div_rsp_i.quot[dcilm_pkg::DivNumW-1:CntW] != '0) ? '1
                                                                       : div_rsp_i.quot[CntW-1:0];
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcilm_pkg::ST_IDLE: begin
        if (fifo_valid_i && is_query) begin
          state_d = (!tvalid_q || skip_update) ? dcilm_pkg::ST_RESULT : dcilm_pkg::ST_RATE_MUL;
        end
      end
      dcilm_pkg::ST_RATE_MUL: state_d = dcilm_pkg::ST_RATE_GO;
      dcilm_pkg::ST_RATE_GO:  state_d = dcilm_pkg::ST_RATE_WAIT;
      dcilm_pkg::ST_RATE_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = ci_q ? dcilm_pkg::ST_APPLY : dcilm_pkg::ST_RATE_MUL;
        end
      end
      dcilm_pkg::ST_APPLY: begin
        state_d = cal_q ? dcilm_pkg::ST_LOAD_MUL : dcilm_pkg::ST_RESULT;
      end
      dcilm_pkg::ST_LOAD_MUL: begin
        if (load_zero) begin
          state_d = ci_q ? dcilm_pkg::ST_RESULT : dcilm_pkg::ST_LOAD_MUL;
        end else begin
          state_d = dcilm_pkg::ST_LOAD_GO;
        end
      end
      dcilm_pkg::ST_LOAD_GO: state_d = dcilm_pkg::ST_LOAD_WAIT;
      dcilm_pkg::ST_LOAD_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = ci_q ? dcilm_pkg::ST_RESULT : dcilm_pkg::ST_LOAD_MUL;
        end
      end
      dcilm_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = dcilm_pkg::ST_IDLE;
        end
      end
      default: state_d = dcilm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    fifo_pop_o      = (state_q == dcilm_pkg::ST_IDLE) && fifo_valid_i;
    div_req_o.start = (state_q == dcilm_pkg::ST_RATE_GO) || (state_q == dcilm_pkg::ST_LOAD_GO);
    div_req_o.num   = prod_q;
    div_req_o.den   = (state_q == dcilm_pkg::ST_RATE_GO) ? dt_q : NowW'(max_q[ci_q]);
    out_load        = (state_q == dcilm_pkg::ST_RESULT) && out_free;
  end

  assign load_sel = (core_q < dcilm_pkg::CoreIdW'(NC)) ? load_q[core_q[0]] : '0;
  assign load_sum = {1'b0, load_q[0]} + {1'b0, load_q[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dcilm_pkg::ST_IDLE;
      for (int i = 0; i < NC; i++) begin
        cnt_q[i]  <= '0;
        max_q[i]  <= '0;
        load_q[i] <= '0;
      end
      last_q        <= '0;
      tvalid_q      <= 1'b0;
      cal_start_q   <= '0;
      cal_started_q <= 1'b0;
      cal_q         <= 1'b0;
      win_q         <= dcilm_pkg::WindowReset;
      calus_q       <= dcilm_pkg::CalibReset;
      ci_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (dcilm_pkg::cfg_idx_e'(cfg_idx_i))
          dcilm_pkg::CFG_WINDOW: win_q   <= cfg_data_i[dcilm_pkg::WindowW-1:0];
          dcilm_pkg::CFG_CALIB:  calus_q <= cfg_data_i[dcilm_pkg::CalibW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        dcilm_pkg::ST_IDLE: begin
          if (fifo_valid_i) begin
            if (!is_query) begin
              if (cnt_q[fifo_item_i.core_id[0]] != '1) begin
                cnt_q[fifo_item_i.core_id[0]] <= cnt_q[fifo_item_i.core_id[0]] + 1'b1;
              end
            end else begin
              ci_q <= 1'b0;
              if (!tvalid_q) begin
                last_q   <= fifo_item_i.now_us;
                tvalid_q <= 1'b1;
              end
            end
          end
        end
        dcilm_pkg::ST_RATE_MUL: cnt_q[ci_q] <= '0;
        dcilm_pkg::ST_RATE_WAIT: begin
          if (div_rsp_i.done) begin
            ci_q <= !ci_q;
          end
        end
        dcilm_pkg::ST_APPLY: begin
          last_q <= now_q;
          ci_q   <= 1'b0;
          if (!cal_q) begin
            for (int i = 0; i < NC; i++) begin
              max_q[i]  <= new_max[i];
              load_q[i] <= '0;
            end
            if (!cal_started_q) begin
              cal_start_q   <= now_q;
              cal_started_q <= 1'b1;
            end
            if (cal_end) begin
              cal_q <= 1'b1;
            end
          end
        end
        dcilm_pkg::ST_LOAD_MUL: begin
          if (load_zero) begin
            load_q[ci_q] <= '0;
            ci_q         <= !ci_q;
          end
        end
        dcilm_pkg::ST_LOAD_WAIT: begin
          if (div_rsp_i.done) begin
            load_q[ci_q] <= div_rsp_i.quot[LoadW-1:0];
            ci_q         <= !ci_q;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == dcilm_pkg::ST_IDLE) && fifo_valid_i && is_query) begin
      now_q  <= fifo_item_i.now_us;
      core_q <= fifo_item_i.core_id;
      dt_q   <= dt_c;
    end
    if (state_q == dcilm_pkg::ST_RATE_MUL) begin
      prod_q <= dcilm_pkg::DivNumW'(cnt_q[ci_q]) * dcilm_pkg::DivNumW'(dcilm_pkg::UsPerSec);
    end else if (state_q == dcilm_pkg::ST_LOAD_MUL) begin
      prod_q <= dcilm_pkg::DivNumW'(dcilm_pkg::FullLoad) *
                dcilm_pkg::DivNumW'(max_q[ci_q] - rate_q[ci_q]);
    end
    if ((state_q == dcilm_pkg::ST_RATE_WAIT) && div_rsp_i.done) begin
      rate_q[ci_q] <= rate_sat;
    end
    if (out_load) begin
      out_data_q <= {1'b0, cal_q, load_sum[LoadW:1], load_sel};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
